FILE: hdl/request_pacing_queue_defines.svh
// assertion macros for the request pacing queue checker
// depends on nothing; included by the checker file
`ifndef REQUEST_PACING_QUEUE_DEFINES_SVH
`define REQUEST_PACING_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RPQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("request pacing queue check failed");

// next-cycle implication, checked outside reset
`define RPQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("request pacing queue check failed");

`endif

FILE: hdl/rpq_pkg.sv
// shared types, constants and helpers of the request pacing queue
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package rpq_pkg;

  localparam int QueueDepth = 1024;
  localparam int MaxRelease = 64;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int RelW       = $clog2(MaxRelease + 1);
  localparam int IdW        = 32;
  localparam int TimeW      = 48;
  localparam int DelayW     = 24;

  localparam logic [DelayW-1:0] DelayReset = DelayW'(500);
  localparam logic [TimeW-1:0]  TimeMax    = {TimeW{1'b1}};

  typedef enum logic [0:0] {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_QUEUED   = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_RELEASED = 2'd2
  } kind_e;

  typedef struct packed {
    logic             func;
    logic [IdW-1:0]   request_id;
    logic [TimeW-1:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [IdW-1:0]   out_request_id;
    logic [TimeW-1:0] release_time;
    logic             last_of_run;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e              op;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] now;
  } cmd_t;

  // circular index step, also for depths that are not a power of two
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    if (i == IdxW'(QueueDepth - 1)) r = '0;
    else r = i + 1'b1;
    return r;
  endfunction

endpackage

FILE: hdl/rpq_front.sv
// front end: takes words, classifies them and holds them in a two-entry command queue
// depends on rpq_pkg
`timescale 1ns / 1ps

module rpq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rpq_pkg::in_word_t item_i,
  output logic              busy_o,
  output logic              cmd_valid_o,
  output rpq_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  rpq_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push;
  rpq_pkg::cmd_t cmd_new;

  // classify the incoming word
  always_comb begin
    cmd_new.op  = rpq_pkg::op_e'(item_i.func);
    cmd_new.now = item_i.now_time;
    if (cmd_new.op == rpq_pkg::OP_TICK) cmd_new.id = '0;
    else cmd_new.id = item_i.request_id;
  end

  assign busy_o      = fill_q[1];
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = fill_q != 2'd0;
  assign cmd_o       = slot_q[rd_ptr_q];

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    fill_d   = fill_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= cmd_new;
  end

endmodule

FILE: hdl/rpq_back.sv
// back end: pacing arithmetic, request memory and release sequencer
// depends on rpq_pkg
`timescale 1ns / 1ps

module rpq_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rpq_pkg::DelayW-1:0]   cfg_wdata_i,
  input  logic                         cmd_valid_i,
  input  rpq_pkg::cmd_t                cmd_i,
  output logic                         cmd_pop_o,
  output logic                         result_valid_o,
  output rpq_pkg::out_word_t           result_o
);

  localparam int MemW = rpq_pkg::IdW + rpq_pkg::TimeW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BASE  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_TCHK  = 4'b1000
  } st_e;

  st_e                            state_q, state_d;
  rpq_pkg::cmd_t                  cmd_q, cmd_d;
  logic [rpq_pkg::DelayW-1:0]     delay_q;
  logic [rpq_pkg::TimeW-1:0]      last_q, last_d;
  logic [rpq_pkg::TimeW-1:0]      base_q, base_d;
  logic [rpq_pkg::IdxW-1:0]       head_q, head_d;
  logic [rpq_pkg::IdxW-1:0]       tail_q, tail_d;
  logic [rpq_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [rpq_pkg::RelW-1:0]       n_q, n_d;
  logic                           pend_v_q, pend_v_d;
  rpq_pkg::out_word_t             pend_q, pend_d;
  logic                           res_v_q, res_v_d;
  rpq_pkg::out_word_t             res_q, res_d;

  logic [MemW-1:0]                mem_q [rpq_pkg::QueueDepth];
  logic [MemW-1:0]                rd_q;
  logic [rpq_pkg::IdxW-1:0]       rd_addr;
  logic                           mem_we;
  logic [MemW-1:0]                mem_wdata;

  logic [rpq_pkg::TimeW:0]        sum;
  logic [rpq_pkg::TimeW-1:0]      rel;
  logic [rpq_pkg::IdW-1:0]        rd_id;
  logic [rpq_pkg::TimeW-1:0]      rd_time;
  logic                           full;
  logic                           due;

  assign full    = cnt_q == rpq_pkg::CntW'(rpq_pkg::QueueDepth);
  assign rd_id   = rd_q[MemW-1 -: rpq_pkg::IdW];
  assign rd_time = rd_q[rpq_pkg::TimeW-1:0];
  assign rd_addr = (state_q == ST_TCHK) ? rpq_pkg::next_idx(head_q) : head_q;

  // release time: base plus delay, clamped at the top of the time range
  assign sum = {1'b0, base_q} + {{(rpq_pkg::TimeW + 1 - rpq_pkg::DelayW){1'b0}}, delay_q};
  assign rel = sum[rpq_pkg::TimeW] ? rpq_pkg::TimeMax : sum[rpq_pkg::TimeW-1:0];

  // head entry is due while below the tick time and the run budget lasts
  assign due = (cnt_q != '0) && (n_q < rpq_pkg::RelW'(rpq_pkg::MaxRelease))
               && (rd_time < cmd_q.now);

  assign cmd_pop_o      = (state_q == ST_IDLE) && cmd_valid_i;
  assign mem_wdata      = {cmd_q.id, rel};
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    last_d   = last_q;
    base_d   = base_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    res_v_d  = 1'b0;
    res_d    = res_q;
    mem_we   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          n_d      = '0;
          pend_v_d = 1'b0;
          if (cmd_i.op == rpq_pkg::OP_TICK) state_d = ST_TCHK;
          else state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        if (full) begin
          res_v_d              = 1'b1;
          res_d.event_kind     = rpq_pkg::KIND_REJECTED;
          res_d.out_request_id = cmd_q.id;
          res_d.release_time   = '0;
          res_d.last_of_run    = 1'b1;
          state_d              = ST_IDLE;
        end else begin
          base_d  = (last_q > cmd_q.now) ? last_q : cmd_q.now;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we               = 1'b1;
        last_d               = rel;
        tail_d               = rpq_pkg::next_idx(tail_q);
        cnt_d                = cnt_q + 1'b1;
        res_v_d              = 1'b1;
        res_d.event_kind     = rpq_pkg::KIND_QUEUED;
        res_d.out_request_id = cmd_q.id;
        res_d.release_time   = rel;
        res_d.last_of_run    = 1'b1;
        state_d              = ST_IDLE;
      end
      ST_TCHK: begin
        // a released word is held in the pending register and goes out once we know if it ends the run
        if (pend_v_q) begin
          res_v_d           = 1'b1;
          res_d             = pend_q;
          res_d.last_of_run = !due;
        end
        if (due) begin
          pend_v_d              = 1'b1;
          pend_d.event_kind     = rpq_pkg::KIND_RELEASED;
          pend_d.out_request_id = rd_id;
          pend_d.release_time   = rd_time;
          pend_d.last_of_run    = 1'b0;
          head_d                = rpq_pkg::next_idx(head_q);
          cnt_d                 = cnt_q - 1'b1;
          n_d                   = n_q + 1'b1;
        end else begin
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      delay_q  <= rpq_pkg::DelayReset;
      last_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) delay_q <= cfg_wdata_i;
      last_q   <= last_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    base_q <= base_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  // request memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[tail_q] <= mem_wdata;
    rd_q <= mem_q[rd_addr];
  end

endmodule

FILE: hdl/request_pacing_queue.sv
// Request pacing queue. A word with func low is an arrival: it is rejected when the
// queue holds its full depth of requests, otherwise it is given a release time of
// max(last release, now) plus pacing_delay (clamped at the top of the 48-bit range)
// and queued; either way one result word follows. A word with func high is a tick:
// queued requests whose release time lies strictly below now are released in order,
// at most 64 per tick, one result word per cycle with last_of_run on the final one;
// a tick with nothing due gives no result. Results appear for one cycle on
// result_valid_o and cannot be held off. Inside, a queued arrival takes the back-end
// steps dispatch, base compare, and add with memory write; a rejected one stops after
// the base compare, and a tick is paced by the single read port of the
// request memory, which releases one entry per cycle. The front end holds two further
// words, so busy rises only when both are waiting. Write pacing_delay only while the
// block is idle.
// depends on rpq_pkg, rpq_front, rpq_back
`timescale 1ns / 1ps

module request_pacing_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rpq_pkg::in_word_t           item_i,
  output logic                        busy,
  input  logic                        cfg_we_i,
  input  logic [rpq_pkg::DelayW-1:0]  cfg_wdata_i,
  output logic                        result_valid_o,
  output rpq_pkg::out_word_t          result_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  rpq_pkg::cmd_t cmd;

  // accept and classify
  rpq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // carry out
  rpq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: hdl/rpq_checker.sv
// port-level checks of the request pacing queue, bound to the top level
// depends on rpq_pkg and request_pacing_queue_defines.svh
`timescale 1ns / 1ps
`include "request_pacing_queue_defines.svh"

module rpq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               result_valid_o,
  input rpq_pkg::out_word_t result_o
);

  // a rejection carries no time and closes its run
  `RPQ_ASSERT_IMP(a_reject_shape, clk_i, rst_ni, result_valid_o && (result_o.event_kind == rpq_pkg::KIND_REJECTED), (result_o.release_time == '0) && result_o.last_of_run)

  // a queued word always closes its run
  `RPQ_ASSERT_IMP(a_queued_last, clk_i, rst_ni, result_valid_o && (result_o.event_kind == rpq_pkg::KIND_QUEUED), result_o.last_of_run)

  // an open release run continues with another release in the next cycle
  `RPQ_ASSERT_NXT(a_run_contig, clk_i, rst_ni, result_valid_o && !result_o.last_of_run, result_valid_o && (result_o.event_kind == rpq_pkg::KIND_RELEASED))

endmodule

bind request_pacing_queue rpq_checker u_rpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
